/* sv/rc4_pkg.sv */
// Shared constants, payload types and control/status bundles for the RC4 cipher block.
package rc4_pkg;

  localparam int MAX_KEY       = 32;
  localparam int MAX_WORD_BITS = 8;
  localparam int BYTE_W        = 8;
  localparam int WB_W          = 4;
  localparam int SBOX_AW       = MAX_WORD_BITS;
  localparam int SBOX_DEPTH    = 1 << SBOX_AW;
  localparam int KEY_AW        = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int KCNT_W        = $clog2(MAX_KEY + 1);

  localparam logic [WB_W-1:0] WB_RESET = WB_W'(MAX_WORD_BITS);

  localparam logic CMD_KEY = 1'b0;
  localparam logic CMD_MSG = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] byte_value;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [BYTE_W-1:0] keystream_word;
    logic              keyed;
    logic              last_out;
  } out_item_t;

  typedef struct packed {
    logic key_wr;
    logic item_ld;
    logic n_clr;
    logic init_wr;
    logic ks_rd_n;
    logic ks_rd_j;
    logic ks_wr_j;
    logic ks_wr_n;
    logic ks_done;
    logic pg_rd_i;
    logic pg_rd_j;
    logic pg_wr_j;
    logic pg_wr_i;
    logic out_ld;
    logic out_pass;
  } dp_cmd_t;

  typedef struct packed {
    logic keyed;
    logic n_last;
  } dp_stat_t;

  // word size 0 acts as 1, anything above the maximum acts as the maximum
  function automatic logic [SBOX_AW-1:0] size_mask(input logic [WB_W-1:0] wb);
    logic [WB_W-1:0]  w;
    logic [SBOX_AW:0] full;
    w = wb;
    if (w == '0) w = WB_W'(1);
    if (w > WB_W'(MAX_WORD_BITS)) w = WB_W'(MAX_WORD_BITS);
    full = ((SBOX_AW + 1)'(1) << w) - (SBOX_AW + 1)'(1);
    return full[SBOX_AW-1:0];
  endfunction

endpackage

/* sv/rc4_ctrl.sv */
// Sequencer for key scheduling, keystream steps and result hand-off.
module rc4_ctrl import rc4_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_INIT     = 12'b0000_0000_0010,
    ST_KS_RD_N  = 12'b0000_0000_0100,
    ST_KS_RD_J  = 12'b0000_0000_1000,
    ST_KS_WR_J  = 12'b0000_0001_0000,
    ST_KS_WR_N  = 12'b0000_0010_0000,
    ST_PG_RD_I  = 12'b0000_0100_0000,
    ST_PG_RD_J  = 12'b0000_1000_0000,
    ST_PG_WR_J  = 12'b0001_0000_0000,
    ST_PG_WR_I  = 12'b0010_0000_0000,
    ST_PG_OUT   = 12'b0100_0000_0000,
    ST_PASS_OUT = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.cmd == CMD_KEY) begin
            cmd.key_wr = 1'b1;
            if (in_item.last) begin
              cmd.n_clr = 1'b1;
              state_nxt = ST_INIT;
            end
          end else begin
            cmd.item_ld = 1'b1;
            state_nxt   = stat.keyed ? ST_PG_RD_I : ST_PASS_OUT;
          end
        end
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.n_last) begin
          cmd.n_clr = 1'b1;
          state_nxt = ST_KS_RD_N;
        end
      end
      ST_KS_RD_N: begin
        cmd.ks_rd_n = 1'b1;
        state_nxt   = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        cmd.ks_rd_j = 1'b1;
        state_nxt   = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        cmd.ks_wr_j = 1'b1;
        state_nxt   = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        cmd.ks_wr_n = 1'b1;
        if (stat.n_last) begin
          cmd.ks_done = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_KS_RD_N;
        end
      end
      ST_PG_RD_I: begin
        cmd.pg_rd_i = 1'b1;
        state_nxt   = ST_PG_RD_J;
      end
      ST_PG_RD_J: begin
        cmd.pg_rd_j = 1'b1;
        state_nxt   = ST_PG_WR_J;
      end
      ST_PG_WR_J: begin
        cmd.pg_wr_j = 1'b1;
        state_nxt   = ST_PG_WR_I;
      end
      ST_PG_WR_I: begin
        cmd.pg_wr_i = 1'b1;
        state_nxt   = ST_PG_OUT;
      end
      ST_PG_OUT: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_PASS_OUT: begin
        if (out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_pass = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/rc4_dp.sv */
// S-box and key memories, generator indices and result register.
module rc4_dp import rc4_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [WB_W-1:0]   cfg_wr_data,
  input  in_item_t          in_item,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output out_item_t         out_item
);

  logic [SBOX_AW-1:0] sbox_mem [SBOX_DEPTH];
  logic [BYTE_W-1:0]  key_mem  [MAX_KEY];

  logic [WB_W-1:0]    wb_r;
  logic [KCNT_W-1:0]  key_cnt_r;
  logic [KEY_AW-1:0]  kidx_r, kidx_nxt;
  logic [SBOX_AW-1:0] n_r, i_r, j_r;
  logic               keyed_r;
  logic [SBOX_AW-1:0] si_r, sj_r, sb_rd_r;
  logic [BYTE_W-1:0]  key_rd_r;
  logic               byp_r;
  logic [BYTE_W-1:0]  msg_r;
  logic               last_r;
  out_item_t          out_r;

  logic [SBOX_AW-1:0] mask, i_inc, ks_j, pg_j, t_idx, ks_word;
  logic [KCNT_W-1:0]  key_len;
  logic               key_room;
  logic               sb_wr_en, sb_rd_en;
  logic [SBOX_AW-1:0] sb_wr_addr, sb_wr_data, sb_rd_addr;
  logic [BYTE_W-1:0]  ks_byte;

  assign mask     = size_mask(wb_r);
  assign i_inc    = (i_r + SBOX_AW'(1)) & mask;
  assign ks_j     = (j_r + sb_rd_r + key_rd_r[SBOX_AW-1:0]) & mask;
  assign pg_j     = (j_r + sb_rd_r) & mask;
  assign t_idx    = (si_r + sj_r) & mask;
  assign key_room = (key_cnt_r < KCNT_W'(MAX_KEY));
  assign key_len  = (key_cnt_r == '0) ? KCNT_W'(1) : key_cnt_r;
  assign kidx_nxt = ((KCNT_W'(kidx_r) + KCNT_W'(1)) == key_len) ? '0 : kidx_r + KEY_AW'(1);
  assign ks_word  = cmd.out_pass ? '0 : ((byp_r ? sj_r : sb_rd_r) & mask);
  assign ks_byte  = BYTE_W'(ks_word);

  always_comb begin
    sb_wr_en   = 1'b1;
    sb_wr_addr = '0;
    sb_wr_data = '0;
    unique if (cmd.init_wr) begin
      sb_wr_addr = n_r;
      sb_wr_data = n_r;
    end else if (cmd.ks_wr_j || cmd.pg_wr_j) begin
      sb_wr_addr = j_r;
      sb_wr_data = si_r;
    end else if (cmd.ks_wr_n) begin
      sb_wr_addr = n_r;
      sb_wr_data = sj_r;
    end else if (cmd.pg_wr_i) begin
      sb_wr_addr = i_r;
      sb_wr_data = sj_r;
    end else begin
      sb_wr_en = 1'b0;
    end
  end

  always_comb begin
    sb_rd_en   = 1'b1;
    sb_rd_addr = '0;
    unique if (cmd.ks_rd_n) begin
      sb_rd_addr = n_r;
    end else if (cmd.ks_rd_j) begin
      sb_rd_addr = ks_j;
    end else if (cmd.pg_rd_i) begin
      sb_rd_addr = i_inc;
    end else if (cmd.pg_rd_j) begin
      sb_rd_addr = pg_j;
    end else if (cmd.pg_wr_i) begin
      sb_rd_addr = t_idx;
    end else begin
      sb_rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sb_wr_en) sbox_mem[sb_wr_addr] <= sb_wr_data;
    if (sb_rd_en) sb_rd_r <= sbox_mem[sb_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr && key_room) key_mem[key_cnt_r[KEY_AW-1:0]] <= in_item.byte_value;
    if (cmd.ks_rd_n) key_rd_r <= key_mem[kidx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r      <= WB_RESET;
      key_cnt_r <= '0;
      kidx_r    <= '0;
      n_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
      keyed_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) wb_r <= cfg_wr_data;
      if (cmd.ks_done) begin
        key_cnt_r <= '0;
      end else if (cmd.key_wr && key_room) begin
        key_cnt_r <= key_cnt_r + KCNT_W'(1);
      end
      if (cmd.n_clr) begin
        n_r    <= '0;
        kidx_r <= '0;
      end else if (cmd.init_wr) begin
        n_r <= n_r + SBOX_AW'(1);
      end else if (cmd.ks_wr_n) begin
        n_r    <= n_r + SBOX_AW'(1);
        kidx_r <= kidx_nxt;
      end
      if (cmd.ks_done) begin
        i_r <= '0;
      end else if (cmd.pg_rd_i) begin
        i_r <= i_inc;
      end
      if (cmd.n_clr || cmd.ks_done) begin
        j_r <= '0;
      end else if (cmd.ks_rd_j) begin
        j_r <= ks_j;
      end else if (cmd.pg_rd_j) begin
        j_r <= pg_j;
      end
      if (cmd.ks_done) keyed_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ks_rd_j || cmd.pg_rd_j) si_r <= sb_rd_r;
    if (cmd.ks_wr_j || cmd.pg_wr_j) sj_r <= sb_rd_r;
    // lookup at the index just written reads the new word from sj
    if (cmd.pg_wr_i) byp_r <= (t_idx == i_r);
    if (cmd.item_ld) begin
      msg_r  <= in_item.byte_value;
      last_r <= in_item.last;
    end
    if (cmd.out_ld) begin
      out_r.out_byte       <= msg_r ^ ks_byte;
      out_r.keystream_word <= ks_byte;
      out_r.keyed          <= keyed_r;
      out_r.last_out       <= last_r;
    end
  end

  assign stat.keyed  = keyed_r;
  assign stat.n_last = (n_r == mask);
  assign out_item    = out_r;

endmodule

/* sv/rc4_stream_cipher.sv */
// Top level of the RC4 stream cipher with configurable word size.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_stall  | in_item: cmd, byte_value, last
//  out      | out_valid/ out_stall | out_item: out_byte, keystream_word, keyed, last_out
//  cfg      | cfg_wr_en            | cfg_wr_data: word_bits
//
// A key byte other than the last is taken without a stall; a last key byte holds the input
// through the identity fill of the 2^word_bits S-box entries, then swaps that read S[n] and
// S[j] and write S[j] and S[n]. A keyed message byte holds it through two reads, two writes
// with the lookup beside the second and the result load; an unkeyed one through the load.
// Synchronous active-low reset clears the key count, indices and keyed flag; word_bits = 8.
// A held result waits in the output register; a message finding it stalled waits at its load.
module rc4_stream_cipher import rc4_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [WB_W-1:0] cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  rc4_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .stat        (stat),
    .out_item    (out_item)
  );

endmodule

/* sv/rc4_chk.sv */
// Port-level checks for the RC4 cipher, bound to the top level.
module rc4_chk import rc4_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input in_item_t        in_item,
  input logic            out_valid,
  input logic            out_stall,
  input out_item_t       out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or busy after reset");

  a_msg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.cmd == CMD_MSG) |=> in_stall)
    else $error("message transfer did not occupy the block");

  a_key_absorb: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.cmd == CMD_KEY) && !in_item.last |=> !in_stall)
    else $error("plain key byte stalled the input");

  a_unkeyed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.keyed |-> out_item.keystream_word == '0)
    else $error("keystream word without a key");

endmodule

bind rc4_stream_cipher rc4_chk u_rc4_chk (.*);
